FILE: rtl/three_axis_biquad_lowpass_unit_defines.svh
// Assertion macros used by the filter control RTL.
`ifndef THREE_AXIS_BIQUAD_LOWPASS_UNIT_DEFINES_SVH
`define THREE_AXIS_BIQUAD_LOWPASS_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define BQL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property in the cycle right after a reset edge.
`define BQL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (prop)) else $error(msg);

`endif

FILE: rtl/bql_pkg.sv
package bql_pkg;

  // Lane count follows the fixed x/y/z ports.
  localparam int LANES      = 3;
  localparam int COEF_W     = 32;
  localparam int FRAC_BITS  = 28;
  localparam int NUM_COEFS  = 5;
  localparam int CFG_IDX_W  = 3;

  // Register indexes on the config port.
  localparam logic [CFG_IDX_W-1:0] CFG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_A2 = 3'd4;

  // Unity gain in Q3.28.
  localparam logic [COEF_W-1:0] COEF_ONE  = 32'h1000_0000;
  localparam logic [COEF_W-1:0] COEF_ZERO = 32'h0000_0000;

  typedef struct packed {
    logic [COEF_W-1:0] b0;
    logic [COEF_W-1:0] b1;
    logic [COEF_W-1:0] b2;
    logic [COEF_W-1:0] a1;
    logic [COEF_W-1:0] a2;
  } coef_set_t;

  // Per-cycle pipeline moves, shared by all lanes.
  typedef struct packed {
    logic acc;        // input beat taken into stage A
    logic acc_prime;  // that beat primes the input history
    logic a_adv;      // stage A moves into stage B
    logic b_adv;      // stage B moves into the output stage
    logic b_prime;    // the beat leaving stage B primes the output history
  } bql_step_t;

endpackage

FILE: rtl/bql_lane.sv
module bql_lane
  import bql_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  coef_set_t                     coefs,
  input  bql_step_t                     step,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic signed [SAMPLE_BITS-1:0] out_sample
);

  localparam int PW = COEF_W + SAMPLE_BITS;
  localparam int AW = PW + 3;
  localparam int VW = AW - FRAC_BITS;
  localparam int HW = VW - SAMPLE_BITS + 1;
  localparam logic signed [AW-1:0] ROUND_BIAS =
    {{(AW - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [SAMPLE_BITS-1:0] x1_r, x2_r, xa_r, xb_r, y1_r, y2_r;
  logic signed [PW-1:0]          pb0_r, pb1_r, pb2_r;
  logic signed [AW-1:0]          ff_r;
  logic signed [PW-1:0]          prod0, prod1, prod2, fb1, fb2;
  logic signed [AW-1:0]          ff_nxt, total;
  logic signed [VW-1:0]          scaled;
  logic        [HW-1:0]          head;
  logic signed [SAMPLE_BITS-1:0] y_nxt;

  // Feed-forward products against the input history
  assign prod0 = $signed(coefs.b0) * in_sample;
  assign prod1 = $signed(coefs.b1) * x1_r;
  assign prod2 = $signed(coefs.b2) * x2_r;

  always_ff @(posedge clk) begin
    if (step.acc) begin
      pb0_r <= prod0;
      pb1_r <= prod1;
      pb2_r <= prod2;
      xa_r  <= in_sample;
      if (step.acc_prime) begin
        x1_r <= in_sample;
        x2_r <= in_sample;
      end else begin
        x2_r <= x1_r;
        x1_r <= in_sample;
      end
    end
  end

  // Sum feed-forward terms and add the rounding bias
  assign ff_nxt = {{3{pb0_r[PW-1]}}, pb0_r} + {{3{pb1_r[PW-1]}}, pb1_r}
                + {{3{pb2_r[PW-1]}}, pb2_r} + ROUND_BIAS;

  always_ff @(posedge clk) begin
    if (step.a_adv) begin
      ff_r <= ff_nxt;
      xb_r <= xa_r;
    end
  end

  // Close the feedback loop: subtract output terms, scale, saturate
  assign fb1    = $signed(coefs.a1) * y1_r;
  assign fb2    = $signed(coefs.a2) * y2_r;
  assign total  = ff_r - {{3{fb1[PW-1]}}, fb1} - {{3{fb2[PW-1]}}, fb2};
  assign scaled = total[AW-1:FRAC_BITS];
  assign head   = scaled[VW-1:SAMPLE_BITS-1];

  always_comb begin
    if ((&head) || !(|head)) begin
      y_nxt = scaled[SAMPLE_BITS-1:0];
    end else if (scaled[VW-1]) begin
      y_nxt = SAT_MIN;
    end else begin
      y_nxt = SAT_MAX;
    end
  end

  // The newest output doubles as the result register
  always_ff @(posedge clk) begin
    if (step.b_adv) begin
      if (step.b_prime) begin
        y1_r <= xb_r;
        y2_r <= xb_r;
      end else begin
        y2_r <= y1_r;
        y1_r <= y_nxt;
      end
    end
  end

  assign out_sample = y1_r;

endmodule

FILE: rtl/bql_ctrl.sv
`include "three_axis_biquad_lowpass_unit_defines.svh"

module bql_ctrl
  import bql_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output coef_set_t            coefs,
  output bql_step_t            step
);

  coef_set_t coefs_r;
  logic      primed_r;
  logic      a_valid_r, a_prime_r, b_valid_r, b_prime_r, out_valid_r;
  logic      cfg_hit;
  logic      acc, a_adv, b_adv, out_free;

  // Decode coefficient writes; other indexes are dropped
  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_B0, CFG_B1, CFG_B2, CFG_A1, CFG_A2: cfg_hit = 1'b1;
        default:                                cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coefs_r.b0 <= COEF_ONE;
      coefs_r.b1 <= COEF_ZERO;
      coefs_r.b2 <= COEF_ZERO;
      coefs_r.a1 <= COEF_ZERO;
      coefs_r.a2 <= COEF_ZERO;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_B0:  coefs_r.b0 <= cfg_wdata;
        CFG_B1:  coefs_r.b1 <= cfg_wdata;
        CFG_B2:  coefs_r.b2 <= cfg_wdata;
        CFG_A1:  coefs_r.a1 <= cfg_wdata;
        CFG_A2:  coefs_r.a2 <= cfg_wdata;
        default: coefs_r    <= coefs_r;
      endcase
    end
  end

  // Advance the stages back to front
  assign out_free = !out_valid_r || !out_stall;
  assign b_adv    = b_valid_r && out_free;
  assign a_adv    = a_valid_r && (!b_valid_r || b_adv);
  assign in_stall = a_valid_r && !a_adv;
  assign acc      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r    <= 1'b0;
      a_valid_r   <= 1'b0;
      a_prime_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      b_prime_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Any coefficient write forces the next beat to prime again
      if (cfg_hit) begin
        primed_r <= 1'b0;
      end else if (acc) begin
        primed_r <= 1'b1;
      end
      if (acc) begin
        a_prime_r <= !primed_r;
      end
      if (a_adv) begin
        b_prime_r <= a_prime_r;
      end
      a_valid_r   <= acc || (a_valid_r && !a_adv);
      b_valid_r   <= a_adv || (b_valid_r && !b_adv);
      out_valid_r <= b_adv || (out_valid_r && out_stall);
    end
  end

  assign coefs         = coefs_r;
  assign out_valid     = out_valid_r;
  assign step.acc       = acc;
  assign step.acc_prime = !primed_r;
  assign step.a_adv     = a_adv;
  assign step.b_adv     = b_adv;
  assign step.b_prime   = b_prime_r;

  `BQL_ASSERT_RST(a_rst_empty, !a_valid_r && !b_valid_r && !out_valid_r && !primed_r, "pipeline not empty after reset")
  `BQL_ASSERT(a_cfg_unprime, cfg_hit |=> !primed_r, "coefficient write did not clear priming")
  `BQL_ASSERT(a_acc_fills_a, acc |=> a_valid_r, "accepted beat lost at stage A")
  `BQL_ASSERT(a_b_to_out, b_adv |=> out_valid_r, "beat lost between stage B and output")

endmodule

FILE: rtl/three_axis_biquad_lowpass_unit.sv
// Three-axis second-order low-pass (direct form I biquad), one lane per axis,
// five shared Q3.28 coefficients. Takes one beat per clock while out_stall
// stays low; each result is registered in stage A, stage B and the output
// stage after its input beat is taken. The rate is set by the output
// stage, where the two feedback products, the final sum, rounding and
// saturation are all combinational, so each output is ready for the next
// beat. The first beat after reset or after any coefficient write fills all
// histories with its own samples and comes out unchanged. Write coefficients
// only while no beat is in flight.
module three_axis_biquad_lowpass_unit
  import bql_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [COEF_W-1:0]             cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_x,
  input  logic signed [SAMPLE_BITS-1:0] in_y,
  input  logic signed [SAMPLE_BITS-1:0] in_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_x,
  output logic signed [SAMPLE_BITS-1:0] out_y,
  output logic signed [SAMPLE_BITS-1:0] out_z
);

  coef_set_t                     coefs;
  bql_step_t                     step;
  logic signed [SAMPLE_BITS-1:0] lane_in  [LANES];
  logic signed [SAMPLE_BITS-1:0] lane_out [LANES];

  bql_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .coefs     (coefs),
    .step      (step)
  );

  // Split the beat into axes
  assign lane_in[0] = in_x;
  assign lane_in[1] = in_y;
  assign lane_in[2] = in_z;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    bql_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .clk        (clk),
      .coefs      (coefs),
      .step       (step),
      .in_sample  (lane_in[i]),
      .out_sample (lane_out[i])
    );
  end

  // Merge the lane results into one result beat
  assign out_x = lane_out[0];
  assign out_y = lane_out[1];
  assign out_z = lane_out[2];

endmodule

FILE: sim/three_axis_biquad_lowpass_unit_test.sv
module three_axis_biquad_lowpass_unit_test
  import bql_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB            = 24;
  localparam int ACC_W         = 80;
  localparam int SETTLE        = 6;
  localparam int TAIL_CYCLES   = 12;
  localparam int LONG_HOLD     = 80;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 115;
  localparam int RANDOM_PHASES = 8;
  localparam int WALK_STEP     = 65536;
  localparam int MAX_REPORTS   = 40;

  localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

  localparam logic [COEF_W-1:0] C_MAX  = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0] C_MIN  = 32'h8000_0000;
  localparam logic [COEF_W-1:0] C_HALF = 32'h0800_0000;

  // Butterworth low-pass sets in Q3.28: cutoff 0.1 and 0.02 of the sample rate
  localparam logic [COEF_W-1:0] WIDE_B0 = 32'd18107478;
  localparam logic [COEF_W-1:0] WIDE_B1 = 32'd36214956;
  localparam logic [COEF_W-1:0] WIDE_A1 = -32'sd306817358;
  localparam logic [COEF_W-1:0] WIDE_A2 = 32'd110810693;
  localparam logic [COEF_W-1:0] SLOW_B0 = 32'd972005;
  localparam logic [COEF_W-1:0] SLOW_B1 = 32'd1944278;
  localparam logic [COEF_W-1:0] SLOW_A1 = -32'sd489275964;
  localparam logic [COEF_W-1:0] SLOW_A2 = 32'd224729063;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = 2 ** (FRAC_BITS - 1);

  typedef struct packed {
    logic signed [SB-1:0] x;
    logic signed [SB-1:0] y;
    logic signed [SB-1:0] z;
  } axes_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SB-1:0] in_x = '0;
  logic signed [SB-1:0] in_y = '0;
  logic signed [SB-1:0] in_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SB-1:0] out_x;
  logic signed [SB-1:0] out_y;
  logic signed [SB-1:0] out_z;

  // Stimulus and expectation stores
  axes_t sample_feed[$];
  axes_t filtered_due[$];
  logic in_beat_taken = 1'b0;

  // Predictor state: shared coefficients, per-lane histories
  logic signed [COEF_W-1:0] coef [NUM_COEFS];
  logic signed [SB-1:0] x_d1 [LANES];
  logic signed [SB-1:0] x_d2 [LANES];
  logic signed [SB-1:0] y_d1 [LANES];
  logic signed [SB-1:0] y_d2 [LANES];
  logic filt_primed = 1'b0;

  int walk [LANES];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int fail_count = 0;
  int beats_in = 0;
  int beats_out = 0;
  int cfg_writes = 0;
  int spare_writes = 0;
  int rail_hits = 0;

  three_axis_biquad_lowpass_unit #(
    .SAMPLE_BITS(SB)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_x     (in_x),
    .in_y     (in_y),
    .in_z     (in_z),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_x    (out_x),
    .out_y    (out_y),
    .out_z    (out_z)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // Advance every lane by one sample and return the filtered triple
  function automatic axes_t biquad_step(input axes_t item);
    logic signed [SB-1:0] s [LANES];
    logic signed [SB-1:0] r [LANES];
    logic signed [ACC_W-1:0] acc;
    axes_t res;
    int k;
    s[0] = item.x;
    s[1] = item.y;
    s[2] = item.z;
    for (k = 0; k < LANES; k++) begin
      if (!filt_primed) begin
        // first sample after reset or a coefficient change fills the history
        x_d1[k] = s[k];
        x_d2[k] = s[k];
        y_d1[k] = s[k];
        y_d2[k] = s[k];
        r[k] = s[k];
      end else begin
        acc = ROUND_HALF
            + ACC_W'(coef[0]) * ACC_W'(s[k])
            + ACC_W'(coef[1]) * ACC_W'(x_d1[k])
            + ACC_W'(coef[2]) * ACC_W'(x_d2[k])
            - ACC_W'(coef[3]) * ACC_W'(y_d1[k])
            - ACC_W'(coef[4]) * ACC_W'(y_d2[k]);
        acc = acc >>> FRAC_BITS;
        // clip to the sample range; the clipped value feeds back
        if (acc > ACC_W'(S_MAX)) begin
          r[k] = S_MAX;
          rail_hits++;
        end else if (acc < ACC_W'(S_MIN)) begin
          r[k] = S_MIN;
          rail_hits++;
        end else begin
          r[k] = acc[SB-1:0];
        end
        x_d2[k] = x_d1[k];
        x_d1[k] = s[k];
        y_d2[k] = y_d1[k];
        y_d1[k] = r[k];
      end
    end
    filt_primed = 1'b1;
    res.x = r[0];
    res.y = r[1];
    res.z = r[2];
    return res;
  endfunction

  // Mostly smooth sensor-like walks, some full-range noise, some rails
  function automatic logic signed [SB-1:0] next_sample(input int k);
    logic [31:0] raw;
    longint w;
    int pick;
    pick = $urandom_range(99);
    raw = $urandom;
    if (pick < 70) begin
      w = longint'(walk[k]) + longint'($urandom_range(0, 2 * WALK_STEP)) - WALK_STEP;
      if (w > S_MAX) w = S_MAX;
      if (w < S_MIN) w = S_MIN;
      walk[k] = int'(w);
      return w[SB-1:0];
    end else if (pick < 90) begin
      return raw[SB-1:0];
    end else begin
      case (raw[1:0])
        2'b00:   return S_MAX;
        2'b01:   return S_MIN;
        2'b10:   return '0;
        default: return '1;
      endcase
    end
  endfunction

  function automatic logic [COEF_W-1:0] small_coef();
    logic [31:0] raw;
    raw = $urandom_range(0, 2 ** (FRAC_BITS + 1));
    return raw - 32'(2 ** FRAC_BITS);
  endfunction

  function automatic void offer(input logic signed [SB-1:0] x, input logic signed [SB-1:0] y,
                                input logic signed [SB-1:0] z);
    axes_t item;
    item.x = x;
    item.y = y;
    item.z = z;
    sample_feed.push_back(item);
  endfunction

  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
    // spare indexes are dropped and leave the history primed
    if (idx < NUM_COEFS) begin
      coef[idx] = val;
      filt_primed = 1'b0;
    end else begin
      spare_writes++;
    end
  endtask

  task automatic load_coefs(input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] b1,
                            input logic [COEF_W-1:0] b2, input logic [COEF_W-1:0] a1,
                            input logic [COEF_W-1:0] a2);
    write_coef(CFG_B0, b0);
    write_coef(CFG_B1, b1);
    write_coef(CFG_B2, b2);
    write_coef(CFG_A1, a1);
    write_coef(CFG_A2, a2);
  endtask

  task automatic write_spares();
    int spare;
    logic [31:0] idx;
    for (spare = NUM_COEFS; spare < 2 ** CFG_IDX_W; spare++) begin
      idx = spare;
      write_coef(idx[CFG_IDX_W-1:0], $urandom);
    end
  endtask

  task automatic begin_phase(input int send_pct, input int stall_pct);
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // Hold until every sample is sent and every result is back, then settle
  task automatic drain_all();
    while (sample_feed.size() != 0 || in_valid || filtered_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  // Sender: advance to the next sample once the current beat is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_beat_taken) begin
      if (sample_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_x <= sample_feed[0].x;
        in_y <= sample_feed[0].y;
        in_z <= sample_feed[0].z;
        void'(sample_feed.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold on request
  always @(negedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: predict on each input beat, check each result beat
  always @(posedge clk) begin : check_results
    axes_t want;
    in_beat_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        filtered_due.push_back(biquad_step({in_x, in_y, in_z}));
        beats_in++;
      end
      if (out_valid && !out_stall) begin
        beats_out++;
        if (filtered_due.size() == 0) begin
          report_mismatch($sformatf("result beat %0d with no sample pending", beats_out));
        end else begin
          want = filtered_due.pop_front();
          if (out_x !== want.x)
            report_mismatch($sformatf("beat %0d out_x got %0d want %0d",
                                      beats_out, out_x, want.x));
          if (out_y !== want.y)
            report_mismatch($sformatf("beat %0d out_y got %0d want %0d",
                                      beats_out, out_y, want.y));
          if (out_z !== want.z)
            report_mismatch($sformatf("beat %0d out_z got %0d want %0d",
                                      beats_out, out_z, want.z));
        end
      end
    end
  end

  // Watchdog: end the run if no beat moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", quiet_cycles);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int p;
    int n;
    axes_t item;
    coef[0] = COEF_ONE;
    coef[1] = COEF_ZERO;
    coef[2] = COEF_ZERO;
    coef[3] = COEF_ZERO;
    coef[4] = COEF_ZERO;
    for (n = 0; n < LANES; n++) begin
      x_d1[n] = '0;
      x_d2[n] = '0;
      y_d1[n] = '0;
      y_d2[n] = '0;
      walk[n] = 0;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Unity gain after reset: priming, rails and bit patterns pass through
    begin_phase(0, 0);
    offer(S_MAX, S_MIN, '0);
    offer(S_MIN, S_MAX, '1);
    offer('0, '1, SB'(1));
    offer(SB'(24'h555555), SB'(24'hAAAAAA), SB'(24'h800001));
    offer('1, SB'(1), S_MAX);
    drain_all();

    // Largest positive gain: small inputs scale, large ones clip
    load_coefs(C_MAX, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
    begin_phase(0, 0);
    offer(SB'(5), SB'(-5), '0);
    offer(SB'(1), '1, S_MAX);
    offer(S_MIN, S_MAX, SB'(2));
    offer('1, SB'(1048576), SB'(-1048577));
    offer('0, '0, '0);
    drain_all();

    // Most negative gain flips the rails
    write_coef(CFG_B0, C_MIN);
    begin_phase(0, 0);
    offer('0, '0, '0);
    offer(S_MAX, S_MIN, SB'(1));
    offer(S_MIN, S_MAX, '1);
    drain_all();

    // Half gain: exact halves round toward plus infinity
    write_coef(CFG_B0, C_HALF);
    begin_phase(0, 0);
    offer('0, '0, '0);
    offer(SB'(1), '1, SB'(3));
    offer(SB'(-3), SB'(5), SB'(-5));
    offer(S_MAX, S_MIN, SB'(7));
    drain_all();

    // Extreme taps on both paths, then spare-index writes that keep the history
    load_coefs(C_HALF, C_MAX, C_MIN, C_MIN, C_MAX);
    begin_phase(0, 0);
    offer(SB'(1000), SB'(-1000), '0);
    offer(S_MAX, S_MIN, SB'(12345));
    drain_all();
    write_spares();
    begin_phase(0, 0);
    offer(S_MIN, S_MAX, SB'(-12345));
    offer('0, '0, '0);
    drain_all();

    // Random phases: coefficient choice, idle pattern and sample content vary
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(9))
        0, 1, 2: load_coefs(WIDE_B0, WIDE_B1, WIDE_B0, WIDE_A1, WIDE_A2);
        3, 4:    load_coefs(SLOW_B0, SLOW_B1, SLOW_B0, SLOW_A1, SLOW_A2);
        5:       load_coefs(small_coef(), small_coef(), small_coef(), small_coef(),
                            small_coef());
        6:       load_coefs($urandom, $urandom, $urandom, $urandom, $urandom);
        7:       write_coef(CFG_A1, small_coef());
        8:       write_spares();
        default: ;
      endcase
      case (p % 4)
        0:       begin_phase(0, 0);
        1:       begin_phase(56, 0);
        2:       begin_phase(0, 56);
        default: begin_phase(22, 22);
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        item.x = next_sample(0);
        item.y = next_sample(1);
        item.z = next_sample(2);
        sample_feed.push_back(item);
      end
      // back-pressure the output long enough to fill the pipeline
      if (p == 0) hold_seq++;
      drain_all();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (filtered_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", filtered_due.size()));
    $display("Run sent %0d sample beats and got %0d filtered beats",
             beats_in, beats_out);
    $display("over %0d register writes (%0d spare); %0d samples clipped at a rail.",
             cfg_writes, spare_writes, rail_hits);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
